/* rtl/absscr_pkg.sv */
// ----------------------------------------------------------------------------
// absscr_pkg: shared types, constants and lookup tables
// Constants and salt tables for the audio byte salt scrambler.
// ----------------------------------------------------------------------------
package absscr_pkg;

	localparam int QuadW   = 32;
	localparam int ByteW   = 8;
	localparam int NibW    = 4;
	localparam int ByteLsb = 8;

	localparam logic [NibW-1:0] OffsetMax = 4'd15;
	localparam logic [NibW-1:0] SpecialHi = 4'h9;
	localparam logic [4:0]      HirMod    = 5'd15;

	typedef logic [QuadW-1:0] quad_t;
	typedef logic [ByteW-1:0] byte_t;
	typedef logic [NibW-1:0]  nib_t;

	// scrambler state carried from one beat to the next
	typedef struct packed {
		byte_t salt;
		byte_t index;
		nib_t  offset;
	} state_t;

	// run length per index low nibble
	function automatic nib_t len_lut(input nib_t a);
		nib_t r;
		case (a)
			4'd0:    r = 4'd0;
			4'd1:    r = 4'd1;
			4'd2:    r = 4'd3;
			4'd3:    r = 4'd5;
			4'd4:    r = 4'd7;
			4'd5:    r = 4'd9;
			4'd6:    r = 4'd11;
			4'd7:    r = 4'd13;
			4'd8:    r = 4'd14;
			4'd9:    r = 4'd12;
			4'd10:   r = 4'd10;
			4'd11:   r = 4'd8;
			4'd12:   r = 4'd6;
			4'd13:   r = 4'd4;
			4'd14:   r = 4'd2;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	// low nibble of the salt by position in the run
	function automatic nib_t nib_lut(input nib_t a);
		nib_t r;
		case (a)
			4'd0:    r = 4'h8;
			4'd1:    r = 4'h7;
			4'd2:    r = 4'h9;
			4'd3:    r = 4'h6;
			4'd4:    r = 4'ha;
			4'd5:    r = 4'h5;
			4'd6:    r = 4'hb;
			4'd7:    r = 4'h4;
			4'd8:    r = 4'hc;
			4'd9:    r = 4'h3;
			4'd10:   r = 4'hd;
			4'd11:   r = 4'h2;
			4'd12:   r = 4'he;
			4'd13:   r = 4'h1;
			4'd14:   r = 4'hf;
			default: r = 4'h0;
		endcase
		return r;
	endfunction

	// high nibble of the salt by rotated position
	function automatic nib_t hir_lut(input nib_t a);
		nib_t r;
		case (a)
			4'd0:    r = 4'h0;
			4'd1:    r = 4'h6;
			4'd2:    r = 4'hf;
			4'd3:    r = 4'h8;
			4'd4:    r = 4'h7;
			4'd5:    r = 4'h5;
			4'd6:    r = 4'h3;
			4'd7:    r = 4'h4;
			4'd8:    r = 4'hc;
			4'd9:    r = 4'hd;
			4'd10:   r = 4'he;
			4'd11:   r = 4'h1;
			4'd12:   r = 4'h2;
			4'd13:   r = 4'hb;
			4'd14:   r = 4'ha;
			default: r = 4'h0;
		endcase
		return r;
	endfunction

	// rotation start per index high nibble
	function automatic nib_t hio_lut(input nib_t a);
		nib_t r;
		case (a)
			4'd0:    r = 4'd0;
			4'd1:    r = 4'd11;
			4'd2:    r = 4'd12;
			4'd3:    r = 4'd6;
			4'd4:    r = 4'd7;
			4'd5:    r = 4'd5;
			4'd6:    r = 4'd1;
			4'd7:    r = 4'd4;
			4'd8:    r = 4'd3;
			4'd9:    r = 4'd0;
			4'd10:   r = 4'd14;
			4'd11:   r = 4'd13;
			4'd12:   r = 4'd8;
			4'd13:   r = 4'd9;
			4'd14:   r = 4'd10;
			default: r = 4'd2;
		endcase
		return r;
	endfunction

endpackage

/* rtl/absscr_if.sv */
// ----------------------------------------------------------------------------
// absscr_if: stream channels of the scrambler
// Valid/ready channels for input quadlets and scrambled quadlets.
// ----------------------------------------------------------------------------
interface absscr_in_if;
	import absscr_pkg::*;

	logic  valid;
	logic  ready;
	quad_t data_quadlet;
	logic  restart;

	modport source (output valid, output data_quadlet, output restart, input ready);
	modport sink   (input valid, input data_quadlet, input restart, output ready);
endinterface

interface absscr_out_if;
	import absscr_pkg::*;

	logic  valid;
	logic  ready;
	quad_t scrambled_quadlet;

	modport source (output valid, output scrambled_quadlet, input ready);
	modport sink   (input valid, input scrambled_quadlet, output ready);
endinterface

/* rtl/audio_byte_salt_scrambler.sv */
// ----------------------------------------------------------------------------
// audio_byte_salt_scrambler: salted byte scrambler for audio quadlets
// XORs bits 15:8 of each quadlet with a salt derived from the preceding run.
// ----------------------------------------------------------------------------
//  channel    dir  payload                         handshake
//  audio_in   in   data_quadlet[31:0], restart     valid/ready
//  audio_out  out  scrambled_quadlet[31:0]         valid/ready
//
//  one beat per cycle while the skid register is empty; results are registered
//  the carried state register is the only loop through the salt tables
//  reset clears the state and the valid flags of the output and skid registers
//  a stalled output fills the skid register; input ready drops only
//  when both are full
// ----------------------------------------------------------------------------
module audio_byte_salt_scrambler (
	input  logic clk,
	input  logic arst_n,
	absscr_in_if.sink    audio_in,
	absscr_out_if.source audio_out
);
	import absscr_pkg::*;

	state_t state_q;
	state_t state_n;
	byte_t  byte_out;
	quad_t  result;
	quad_t  out_q;
	quad_t  skid_q;
	logic   out_valid_q;
	logic   skid_valid_q;
	logic   take;
	logic   pop;

	absscr_salt_gen u_salt_gen (
		.cur      (state_q),
		.restart  (audio_in.restart),
		.byte_in  (audio_in.data_quadlet[ByteLsb +: ByteW]),
		.byte_out (byte_out),
		.nxt      (state_n)
	);

	// handshakes
	assign audio_in.ready = !skid_valid_q;
	assign take           = audio_in.valid && audio_in.ready;
	assign pop            = out_valid_q && audio_out.ready;

	assign result = {audio_in.data_quadlet[QuadW-1:ByteLsb+ByteW], byte_out,
		audio_in.data_quadlet[ByteLsb-1:0]};

	// carried state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (take) begin
			state_q <= state_n;
		end
	end

	// output register and skid stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop)
					skid_valid_q <= 1'b0;
			end else if (take) begin
				if (out_valid_q && !pop)
					skid_valid_q <= 1'b1;
				else
					out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop)
				out_q <= skid_q;
		end else if (take) begin
			if (out_valid_q && !pop)
				skid_q <= result;
			else
				out_q <= result;
		end
	end

	assign audio_out.valid             = out_valid_q;
	assign audio_out.scrambled_quadlet = out_q;

endmodule

/* rtl/absscr_salt_gen.sv */
// ----------------------------------------------------------------------------
// absscr_salt_gen: next state and salt
// Works out the scrambled byte and the state left behind by one beat.
// ----------------------------------------------------------------------------
module absscr_salt_gen (
	input  absscr_pkg::state_t cur,
	input  logic               restart,
	input  absscr_pkg::byte_t  byte_in,
	output absscr_pkg::byte_t  byte_out,
	output absscr_pkg::state_t nxt
);
	import absscr_pkg::*;

	state_t eff;
	byte_t  index_n;
	nib_t   offset_n;
	nib_t   span;
	nib_t   lo;
	nib_t   hi;
	nib_t   hnib;
	logic [4:0] rot_sum;
	logic [4:0] rot_pos;
	logic [4:0] run_pos;

	// restart clears the state ahead of this beat
	assign eff = restart ? '0 : cur;

	assign byte_out = byte_in ^ eff.salt;

	// a nonzero byte opens a new run
	always_comb begin
		if (byte_in != '0) begin
			index_n  = byte_in ^ eff.salt;
			offset_n = '0;
		end else begin
			index_n  = eff.index;
			offset_n = eff.offset;
		end
		if (offset_n != OffsetMax)
			offset_n = offset_n + 4'd1;
	end

	assign lo   = index_n[NibW-1:0];
	assign hi   = index_n[ByteW-1:NibW];
	assign span = len_lut(lo);

	// rotated high nibble position, sum stays below twice the modulus
	assign rot_sum = {1'b0, hio_lut(hi)} + {1'b0, offset_n};
	assign rot_pos = (rot_sum >= HirMod) ? rot_sum - HirMod : rot_sum;
	assign hnib    = (hi == SpecialHi) ? SpecialHi : hir_lut(rot_pos[NibW-1:0]);

	// position in the run, within 0..14 whenever the salt is live
	assign run_pos = 5'd14 + {1'b0, offset_n} - {1'b0, span};

	// salt for the next beat
	always_comb begin
		nxt.index  = index_n;
		nxt.offset = offset_n;
		if (span < offset_n)
			nxt.salt = '0;
		else
			nxt.salt = {hnib, nib_lut(run_pos[NibW-1:0])};
	end

endmodule

/* tb/salt_stream_checker.sv */
// ----------------------------------------------------------------------------
// salt_stream_checker: predicts and checks scrambled audio quadlets
// Watches both channels, keeps its own copy of the salt, index and offset,
// and compares every output beat with the oldest predicted quadlet.
// ----------------------------------------------------------------------------
module salt_stream_checker (
	input  logic  clk,
	input  logic  arst_n,
	absscr_in_if  audio_in,
	absscr_out_if audio_out,
	output int    mismatch_count,
	output int    outstanding
);
	import absscr_pkg::*;

	// salt tables
	localparam nib_t RunLen    [0:15] = '{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11, 4'd13,
		4'd14, 4'd12, 4'd10, 4'd8, 4'd6, 4'd4, 4'd2, 4'd0};
	localparam nib_t LowCode   [0:14] = '{4'h8, 4'h7, 4'h9, 4'h6, 4'ha, 4'h5, 4'hb, 4'h4,
		4'hc, 4'h3, 4'hd, 4'h2, 4'he, 4'h1, 4'hf};
	localparam nib_t HighCode  [0:14] = '{4'h0, 4'h6, 4'hf, 4'h8, 4'h7, 4'h5, 4'h3, 4'h4,
		4'hc, 4'hd, 4'he, 4'h1, 4'h2, 4'hb, 4'ha};
	localparam nib_t HighStart [0:15] = '{4'd0, 4'd11, 4'd12, 4'd6, 4'd7, 4'd5, 4'd1, 4'd4,
		4'd3, 4'd0, 4'd14, 4'd13, 4'd8, 4'd9, 4'd10, 4'd2};

	byte_t salt;
	byte_t pattern;
	nib_t  run_pos;
	quad_t due_quadlets[$];

	// salt for a given pattern index and position in the run
	function automatic byte_t salt_after(input byte_t idx, input nib_t pos_in_run);
		nib_t span;
		nib_t hnib;
		int   pos;
		span = RunLen[idx[3:0]];
		if (span < pos_in_run)
			return '0;
		if (idx[7:4] == SpecialHi)
			hnib = SpecialHi;
		else
			hnib = HighCode[(int'(HighStart[idx[7:4]]) + int'(pos_in_run)) % int'(HirMod)];
		pos = 14 + int'(pos_in_run) - int'(span);
		if (pos > 14)
			pos = 14;
		return {hnib, LowCode[pos]};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		quad_t q;
		quad_t got;
		byte_t b;
		if (!arst_n) begin
			salt           = '0;
			pattern        = '0;
			run_pos        = '0;
			mismatch_count = 0;
			outstanding    = 0;
			due_quadlets.delete();
		end else begin
			// predict the result of each accepted input beat
			if (audio_in.valid && audio_in.ready) begin
				q = audio_in.data_quadlet;
				if (audio_in.restart) begin
					salt    = '0;
					pattern = '0;
					run_pos = '0;
				end
				b = q[ByteLsb +: ByteW];
				if (b != '0) begin
					run_pos = '0;
					pattern = b ^ salt;
				end
				q[ByteLsb +: ByteW] = b ^ salt;
				if (run_pos < OffsetMax)
					run_pos = run_pos + 1'b1;
				salt = salt_after(pattern, run_pos);
				due_quadlets.push_back(q);
			end
			// compare each output beat with the oldest prediction
			if (audio_out.valid && audio_out.ready) begin
				got = audio_out.scrambled_quadlet;
				if (due_quadlets.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected output beat: scrambled_quadlet %h", got);
				end else begin
					q = due_quadlets.pop_front();
					if (got !== q) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("scrambled_quadlet mismatch: expected %h, got %h", q, got);
					end
				end
			end
			outstanding = due_quadlets.size();
		end
	end

endmodule

/* tb/audio_byte_salt_scrambler_test.sv */
// ----------------------------------------------------------------------------
// audio_byte_salt_scrambler_test: stimulus and verdict for the scrambler
// Drives directed and random quadlet runs through the block under several
// idle and stall mixes; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module audio_byte_salt_scrambler_test;
	import absscr_pkg::*;

	localparam int CycleLimit    = 200000;
	localparam int PhaseBeats    = 235;
	localparam int SendIdle [4]  = '{0, 57, 0, 31};
	localparam int StallRate [4] = '{0, 0, 57, 31};

	logic clk = 1'b0;
	logic arst_n;
	int   cycles = 0;
	int   send_idle_pct = 0;
	int   stall_pct = 0;
	int   mismatch_count;
	int   outstanding;

	absscr_in_if  audio_in ();
	absscr_out_if audio_out ();

	audio_byte_salt_scrambler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.audio_in  (audio_in),
		.audio_out (audio_out)
	);

	salt_stream_checker quad_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.audio_in       (audio_in),
		.audio_out      (audio_out),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	always #5 clk = ~clk;

	// random back-pressure on the output
	always @(negedge clk) begin
		audio_out.ready <= ($urandom_range(99) >= stall_pct);
	end

	// run-time guard
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// offer one beat, with random idle cycles first, and wait for acceptance
	task automatic send_beat(input quad_t q, input logic r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			audio_in.valid <= 1'b0;
			@(negedge clk);
		end
		audio_in.valid        <= 1'b1;
		audio_in.data_quadlet <= q;
		audio_in.restart      <= r;
		do @(posedge clk); while (!audio_in.ready);
	endtask

	// stop offering and wait until every predicted result has arrived
	task automatic drain;
		@(negedge clk);
		audio_in.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// runs of a nonzero byte followed by zero bytes, with some noise beats
	task automatic send_runs(input int n);
		int    sent;
		quad_t q;
		sent = 0;
		while (sent < n) begin
			q = $urandom;
			if ($urandom_range(9) == 0) begin
				send_beat(q, 1'($urandom_range(1)));
				sent++;
			end else begin
				if (q[ByteLsb +: ByteW] == '0)
					q[ByteLsb +: ByteW] = byte_t'($urandom_range(255, 1));
				send_beat(q, $urandom_range(24) == 0);
				sent++;
				repeat ($urandom_range(17)) begin
					q = $urandom;
					q[ByteLsb +: ByteW] = '0;
					send_beat(q, 1'b0);
					sent++;
				end
			end
		end
	endtask

	initial begin
		quad_t q;
		audio_in.valid        = 1'b0;
		audio_in.data_quadlet = '0;
		audio_in.restart      = 1'b0;
		arst_n                = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// special high nibble of the index, then a zero run long enough to saturate
		send_beat(32'h0000_9500, 1'b1);
		repeat (16) begin
			q = $urandom;
			q[ByteLsb +: ByteW] = '0;
			send_beat(q, 1'b0);
		end
		// field extremes and restart on an all-ones beat
		send_beat(32'hffff_ffff, 1'b1);
		send_beat(32'h0000_0000, 1'b0);
		send_beat(32'h0000_ff00, 1'b0);
		send_beat(32'hffff_00ff, 1'b0);
		drain();

		// random runs under each idle and stall mix
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = SendIdle[ph];
			stall_pct     = StallRate[ph];
			send_runs(PhaseBeats);
			drain();
		end

		stall_pct = 0;
		repeat (5) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/absscr_pkg.sv
rtl/absscr_if.sv
rtl/absscr_salt_gen.sv
rtl/audio_byte_salt_scrambler.sv
tb/salt_stream_checker.sv
tb/audio_byte_salt_scrambler_test.sv
